// File: hw/rtl/rle_stream_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// rle_stream_decoder_top_assert.svh
// Assertion macros used by the decoder's checker.
// ---------------------------------------------------------------------------
`ifndef RLE_STREAM_DECODER_TOP_ASSERT_SVH
`define RLE_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define RLED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define RLED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rled_pkg.sv
// ---------------------------------------------------------------------------
// rled_pkg
// Types, header constants and mode codes of the run-length stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rled_pkg;

	// Most result requests one input byte can cause (a mismatched header)
	localparam int RLED_MAX_OUT = 6;
	localparam int RLED_CNT_W   = $clog2(RLED_MAX_OUT + 1);

	// File header
	localparam int          MAGIC_LEN = 6;
	localparam logic [7:0]  MAGIC [MAGIC_LEN] = '{8'h78, 8'h74, 8'h52, 8'h4C, 8'h45, 8'h00};
	localparam logic [31:0] VER_SIZE  = 32'h0000_0101;
	localparam logic [31:0] VER_KEY   = 32'h0000_0102;
	localparam logic [7:0]  KEY_XOR   = 8'hA5;

	// Header byte positions
	localparam logic [3:0] PH_MAGIC_LAST = 4'd5;
	localparam logic [3:0] PH_VER_FIRST  = 4'd6;
	localparam logic [3:0] PH_VER_LAST   = 4'd9;
	localparam logic [3:0] PH_SIZE_FIRST = 4'd10;
	localparam logic [3:0] PH_SIZE_LAST  = 4'd13;
	// In decode mode: a repeat run waits for its data byte
	localparam logic [3:0] PH_REP_DATA   = 4'd1;

	// Stream modes
	localparam logic [1:0] MODE_HEADER = 2'd0;
	localparam logic [1:0] MODE_RAW    = 2'd1;
	localparam logic [1:0] MODE_DECODE = 2'd2;
	localparam logic [1:0] MODE_DONE   = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic [6:0] count;
		logic       last;
		logic       trunc;
	} rled_rec_t;

	typedef struct packed {
		logic [RLED_CNT_W-1:0]         count;
		rled_rec_t [RLED_MAX_OUT-1:0] rec;
	} rled_batch_t;

	function automatic rled_rec_t rled_mk_rec(input logic [7:0] data, input logic [6:0] count,
			input logic last, input logic trunc);
		rled_rec_t r;
		r.data  = data;
		r.count = count;
		r.last  = last;
		r.trunc = trunc;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rled_outq.sv
// ---------------------------------------------------------------------------
// rled_outq
// Result register: holds the batch of one byte and shifts it out one per cycle while res_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module rled_outq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        load,
	input  wire rled_pkg::rled_batch_t batch,
	input  wire                        res_ready,
	output logic                       res_valid,
	output rled_pkg::rled_rec_t        res,
	output logic                       can_load
);
	import rled_pkg::*;

	rled_rec_t             rec_q [RLED_MAX_OUT];
	logic [RLED_CNT_W-1:0] cnt_q;
	logic                  take;

	assign res_valid = (cnt_q != '0);
	assign res       = rec_q[0];
	assign take      = res_valid && res_ready;
	// Take a new byte once the held batch is empty or its final request leaves now
	assign can_load  = (cnt_q == '0) || ((cnt_q == RLED_CNT_W'(1)) && res_ready);

	// Advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (take) begin
			cnt_q <= cnt_q - RLED_CNT_W'(1);
		end
	end

	// Load the batch, or shift it down by one request
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RLED_MAX_OUT; i++) begin
				rec_q[i] <= batch.rec[i];
			end
		end else if (take) begin
			for (int i = 0; i < RLED_MAX_OUT - 1; i++) begin
				rec_q[i] <= rec_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rled_parse.sv
// ---------------------------------------------------------------------------
// rled_parse
// Header parser and run decoder: per-byte state and the batch it causes.
// ---------------------------------------------------------------------------
`default_nettype none

module rled_parse (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   take,
	input  wire  [7:0]            in_byte,
	input  wire                   end_of_file,
	output rled_pkg::rled_batch_t batch
);
	import rled_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic [3:0]  ph_q, ph_d;
	logic [7:0]  held_q [MAGIC_LEN];
	logic [7:0]  held_d [MAGIC_LEN];
	logic [31:0] ver_q, ver_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  key_q, key_d;
	logic        lit_q, lit_d;
	logic [6:0]  run_q, run_d;

	logic                  magic_ok;
	logic                  ver_neg;
	logic [6:0]            rep_cnt;
	logic [1:0]            byte_sel;
	logic [RLED_CNT_W-1:0] n;

	// Next state and result batch for the byte at the input
	always_comb begin
		mode_d   = mode_q;
		ph_d     = ph_q;
		ver_d    = ver_q;
		rem_d    = rem_q;
		key_d    = key_q;
		lit_d    = lit_q;
		run_d    = run_q;
		batch    = '0;
		n        = '0;
		magic_ok = 1'b1;
		ver_neg  = 1'b0;
		rep_cnt  = '0;
		byte_sel = '0;
		for (int i = 0; i < MAGIC_LEN; i++) begin
			held_d[i] = held_q[i];
		end

		unique case (mode_q)
			MODE_HEADER: begin
				if (ph_q <= PH_MAGIC_LAST) begin
					// Hold the byte and check the magic once all six are in
					for (int i = 0; i < MAGIC_LEN; i++) begin
						if (ph_q[2:0] == 3'(i)) begin
							held_d[i] = in_byte;
						end
						if (held_d[i] != MAGIC[i]) begin
							magic_ok = 1'b0;
						end
					end
					ph_d = ph_q + 4'd1;
					if ((ph_q == PH_MAGIC_LAST) && magic_ok) begin
						ver_d = '0;
					end else if ((ph_q == PH_MAGIC_LAST) || end_of_file) begin
						// Not our format: replay the held bytes raw
						for (int i = 0; i < MAGIC_LEN; i++) begin
							if (4'(i) <= ph_q) begin
								batch.rec[i] = rled_mk_rec(held_d[i], 7'd1,
									end_of_file && (4'(i) == ph_q), 1'b0);
							end
						end
						n      = RLED_CNT_W'(ph_q) + RLED_CNT_W'(1);
						mode_d = MODE_RAW;
					end
				end else if (ph_q <= PH_VER_LAST) begin
					// Assemble the version, little-endian
					byte_sel = 2'(ph_q - PH_VER_FIRST);
					ver_d    = ver_q | ({24'd0, in_byte} << {byte_sel, 3'd0});
					ph_d     = ph_q + 4'd1;
					if (ph_q == PH_VER_LAST) begin
						ver_neg = ver_d[31];
						if (!ver_neg && (ver_d >= VER_KEY)) begin
							key_d = KEY_XOR;
						end
						if (!ver_neg && (ver_d >= VER_SIZE)) begin
							rem_d = '0;
						end else begin
							batch.rec[0] = rled_mk_rec(8'd0, 7'd0, 1'b1, 1'b0);
							n            = RLED_CNT_W'(1);
							mode_d       = MODE_DONE;
						end
					end
				end else begin
					// Assemble the size, little-endian
					byte_sel = 2'(ph_q - PH_SIZE_FIRST);
					rem_d    = rem_q | ({24'd0, in_byte} << {byte_sel, 3'd0});
					ph_d     = ph_q + 4'd1;
					if (ph_q >= PH_SIZE_LAST) begin
						if ((rem_d == '0) || rem_d[31]) begin
							batch.rec[0] = rled_mk_rec(8'd0, 7'd0, 1'b1, 1'b0);
							n            = RLED_CNT_W'(1);
							mode_d       = MODE_DONE;
						end else begin
							mode_d = MODE_DECODE;
							ph_d   = '0;
							lit_d  = 1'b0;
							run_d  = '0;
						end
					end
				end
			end
			MODE_RAW: begin
				batch.rec[0] = rled_mk_rec(in_byte, 7'd1, end_of_file, 1'b0);
				n            = RLED_CNT_W'(1);
			end
			MODE_DECODE: begin
				if (lit_q && (run_q != '0)) begin
					// Literal byte: unmask and pass one copy
					rem_d        = rem_q - 32'd1;
					batch.rec[0] = rled_mk_rec(in_byte ^ key_q, 7'd1, rem_d == '0, 1'b0);
					n            = RLED_CNT_W'(1);
					run_d        = run_q - 7'd1;
					if (run_d == '0) begin
						lit_d = 1'b0;
					end
					if (rem_d == '0) begin
						mode_d = MODE_DONE;
					end
				end else if (ph_q == PH_REP_DATA) begin
					// Repeat data byte: clip the count to what is still owed
					ph_d = '0;
					if (run_q != '0) begin
						if ((rem_q[31:7] == '0) && (rem_q[6:0] < run_q)) begin
							rep_cnt = rem_q[6:0];
						end else begin
							rep_cnt = run_q;
						end
						rem_d        = rem_q - {25'd0, rep_cnt};
						batch.rec[0] = rled_mk_rec(in_byte, rep_cnt, rem_d == '0, 1'b0);
						n            = RLED_CNT_W'(1);
						if (rem_d == '0) begin
							mode_d = MODE_DONE;
						end
					end
					run_d = '0;
				end else if (in_byte[7]) begin
					// Literal control byte; a zero length opens nothing
					run_d = in_byte[6:0];
					lit_d = (in_byte[6:0] != '0);
				end else begin
					// Repeat control byte
					run_d = in_byte[6:0];
					lit_d = 1'b0;
					ph_d  = PH_REP_DATA;
				end
			end
			MODE_DONE: begin
			end
			default: begin
			end
		endcase

		// End of file: flag an unfinished stream, then start over
		if (end_of_file) begin
			if ((mode_d == MODE_HEADER) || (mode_d == MODE_DECODE)) begin
				for (int i = 0; i < RLED_MAX_OUT; i++) begin
					if (n == RLED_CNT_W'(i)) begin
						batch.rec[i] = rled_mk_rec(8'd0, 7'd0, 1'b1, 1'b1);
					end
				end
				n = n + RLED_CNT_W'(1);
			end
			mode_d = MODE_HEADER;
			ph_d   = '0;
			ver_d  = '0;
			rem_d  = '0;
			key_d  = '0;
			lit_d  = 1'b0;
			run_d  = '0;
		end
		batch.count = n;
	end

	// Update control state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			ph_q   <= '0;
			ver_q  <= '0;
			rem_q  <= '0;
			key_q  <= '0;
			lit_q  <= 1'b0;
			run_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			ph_q   <= ph_d;
			ver_q  <= ver_d;
			rem_q  <= rem_d;
			key_q  <= key_d;
			lit_q  <= lit_d;
			run_q  <= run_d;
		end
	end

	// Hold the header bytes
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < MAGIC_LEN; i++) begin
				held_q[i] <= held_d[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rle_stream_decoder_top.sv
// ---------------------------------------------------------------------------
// rle_stream_decoder_top
// Run-length stream decoder with literal and repeat runs.
// ---------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_ready): one file byte per request, with
//   end_of_file on the final byte of each file.
//   Result channel (result_valid/result_ready): data_byte with repeat_count
//   copies; repeat_count 0 is a status request carrying last/truncated.
//   A byte's first result, if any, appears in the cycle after it is accepted.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and result_ready stays high. A byte yielding k results (up to six, when a
//   non-matching header is replayed) holds the result register until all k
//   are taken; the shift-out of that register is what paces the byte channel then.
//   Stall: byte_ready stays high while the result register is empty or its
//   final request is taken in the same cycle; otherwise input waits.
//   Reset: arst_n clears the parser to await a new header and empties the
//   result register. After end_of_file the parser starts over by itself.
// ---------------------------------------------------------------------------
`default_nettype none

module rle_stream_decoder_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_ready,
	input  wire  [7:0] in_byte,
	input  wire        end_of_file,
	output logic       result_valid,
	input  wire        result_ready,
	output logic [7:0] data_byte,
	output logic [6:0] repeat_count,
	output logic       last,
	output logic       truncated
);
	import rled_pkg::*;

	rled_batch_t batch;
	rled_rec_t   res;
	logic        take;

	assign take = byte_valid && byte_ready;

	// Decode the byte at the input
	rled_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.batch       (batch)
	);

	// Hold its results and hand them out
	rled_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.batch     (batch),
		.res_ready (result_ready),
		.res_valid (result_valid),
		.res       (res),
		.can_load  (byte_ready)
	);

	assign data_byte    = res.data;
	assign repeat_count = res.count;
	assign last         = res.last;
	assign truncated    = res.trunc;

endmodule

`default_nettype wire

// File: hw/rtl/rled_checker.sv
// ---------------------------------------------------------------------------
// rled_checker
// Port-level checks of the decoder, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rle_stream_decoder_top_assert.svh"

module rled_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       byte_ready,
	input wire       result_valid,
	input wire       result_ready,
	input wire [6:0] repeat_count,
	input wire       last,
	input wire       truncated
);

	// A stalled result request stays offered
	`RLED_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// Input only waits behind a pending result
	`RLED_ASSERT_NOW(a_ready_gap, !byte_ready, result_valid, "byte channel blocked with nothing pending")

	// A status-only request closes the stream
	`RLED_ASSERT_NOW(a_status_last, result_valid && (repeat_count == 7'd0), last, "status request without last")

	// A truncation flag rides only on a closing status request
	`RLED_ASSERT_NOW(a_trunc_form, result_valid && truncated, last && (repeat_count == 7'd0), "malformed truncation request")

endmodule

bind rle_stream_decoder_top rled_checker u_rled_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_ready   (byte_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.repeat_count (repeat_count),
	.last         (last),
	.truncated    (truncated)
);

`default_nettype wire
